// ----- design/key_matrix_scanner_top_macros.svh -----
// assertion macros for the key matrix scanner checks
`ifndef KEY_MATRIX_SCANNER_TOP_MACROS_SVH
`define KEY_MATRIX_SCANNER_TOP_MACROS_SVH

// same-cycle implication
`define KMS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("key matrix scanner check failed");

// next-cycle implication
`define KMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("key matrix scanner check failed");

`endif

// ----- design/kms_pkg.sv -----
// shared constants and types of the key matrix scanner
package kms_pkg;

   localparam int PIN_COUNT_DEFAULT = 21;
   localparam int HOLD_WIDTH        = 32;
   localparam int TICK_WIDTH        = 8;
   localparam int CSR_INDEX_WIDTH   = 2;
   localparam int CSR_DATA_WIDTH    = 32;
   localparam logic [TICK_WIDTH-1:0] TICK_RESET = 8'd10;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_INPUT_MASK  = 2'd0,
      CSR_OUTPUT_MASK = 2'd1,
      CSR_GROUND_MASK = 2'd2,
      CSR_TICK        = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } scan_state_type;

endpackage

// ----- design/key_matrix_scanner_top.sv -----
// key matrix scanner: one pin sample in, one drive pattern and scan result out
// a result beat appears in the cycle after its sample beat is taken
// throughput: one sample per cycle, set by the single registered step of the scan state
// a sample is taken while the result register is empty or being drained
// reset (synchronous, active high) clears the scan state, hold time and flag;
// masks clear and the tick interval returns to 10
module key_matrix_scanner_top #(
   parameter int PIN_COUNT = kms_pkg::PIN_COUNT_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [PIN_COUNT-1:0]                 req_pin_levels,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [PIN_COUNT-1:0]                 rsp_drive_levels,
   output logic                                 rsp_scan_done,
   output logic [PIN_COUNT-1:0]                 rsp_key_code,
   output logic [kms_pkg::HOLD_WIDTH-1:0]       rsp_hold_time,
   output logic                                 rsp_repeat_flag,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [kms_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [kms_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   localparam int PosWidth = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;
   localparam int HoldW    = kms_pkg::HOLD_WIDTH;
   localparam int TickW    = kms_pkg::TICK_WIDTH;

   function automatic logic [PosWidth-1:0] top_bit(input logic [PIN_COUNT-1:0] v);
      logic [PosWidth-1:0] pos;
      pos = '0;
      for (int i = 0; i < PIN_COUNT; i++) begin
         if (v[i]) begin
            pos = PosWidth'(i);
         end
      end
      return pos;
   endfunction

   function automatic logic [PIN_COUNT-1:0] pos_bit(input logic [PosWidth-1:0] p);
      return {{(PIN_COUNT-1){1'b0}}, 1'b1} << p;
   endfunction

   // configuration
   logic [PIN_COUNT-1:0] in_mask_ff, out_mask_ff, gnd_mask_ff;
   logic [TickW-1:0]     tick_ff;

   // scan state
   kms_pkg::scan_state_type state_ff, state_in;
   logic [PIN_COUNT-1:0] pend_ff, pend_in;
   logic [PosWidth-1:0]  in_pos_ff, in_pos_in;
   logic [PosWidth-1:0]  out_pos_ff, out_pos_in;
   logic [PIN_COUNT-1:0] acc_ff, acc_in;
   logic [PIN_COUNT-1:0] prev_key_ff, prev_key_in;
   logic [HoldW-1:0]     held_ff, held_in;
   logic                 repeat_ff, repeat_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [PIN_COUNT-1:0] drive_ff, drive_in;
   logic                 done_ff, done_in;
   logic [PIN_COUNT-1:0] code_ff, code_in;

   logic                 req_take;
   logic [PIN_COUNT-1:0] inbit, outbit, lower_outs, pend_next, out_bit_new;
   logic                 finish, hit;
   logic [HoldW:0]       held_sum;

   assign csr_ready = 1'b1;
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_take  = req_valid & ~req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_mask_ff  <= '0;
         out_mask_ff <= '0;
         gnd_mask_ff <= '0;
         tick_ff     <= kms_pkg::TICK_RESET;
      end else if (csr_valid) begin
         case (kms_pkg::csr_index_type'(csr_index))
            kms_pkg::CSR_INPUT_MASK:  in_mask_ff  <= csr_wdata[PIN_COUNT-1:0];
            kms_pkg::CSR_OUTPUT_MASK: out_mask_ff <= csr_wdata[PIN_COUNT-1:0];
            kms_pkg::CSR_GROUND_MASK: gnd_mask_ff <= csr_wdata[PIN_COUNT-1:0];
            kms_pkg::CSR_TICK:        tick_ff     <= csr_wdata[TickW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in    = state_ff;
      pend_in     = pend_ff;
      in_pos_in   = in_pos_ff;
      out_pos_in  = out_pos_ff;
      acc_in      = acc_ff;
      prev_key_in = prev_key_ff;
      held_in     = held_ff;
      repeat_in   = repeat_ff;
      finish      = 1'b0;
      hit         = 1'b0;
      inbit       = pos_bit(in_pos_ff);
      outbit      = pos_bit(out_pos_ff);
      lower_outs  = out_mask_ff & (outbit - {{(PIN_COUNT-1){1'b0}}, 1'b1});
      pend_next   = pend_ff & (inbit - {{(PIN_COUNT-1){1'b0}}, 1'b1});
      held_sum    = {1'b0, held_ff} + (HoldW+1)'(tick_ff);

      case (state_ff)
         kms_pkg::ST_IDLE: begin
            acc_in  = '0;
            pend_in = ~req_pin_levels & in_mask_ff;
            if ((|pend_in) && (|out_mask_ff)) begin
               state_in   = kms_pkg::ST_SCAN;
               in_pos_in  = top_bit(pend_in);
               out_pos_in = top_bit(out_mask_ff);
            end else begin
               finish = 1'b1;
            end
         end
         kms_pkg::ST_SCAN: begin
            hit = ~|(req_pin_levels & inbit);
            if (hit) begin
               acc_in = acc_ff | inbit | outbit;
            end
            if (hit || !(|lower_outs)) begin
               pend_in = pend_next;
               if ((|pend_next) && (|out_mask_ff)) begin
                  in_pos_in  = top_bit(pend_next);
                  out_pos_in = top_bit(out_mask_ff);
               end else begin
                  finish = 1'b1;
               end
            end else begin
               out_pos_in = top_bit(lower_outs);
            end
         end
         default: begin
            finish = 1'b1;
         end
      endcase

      code_in = finish ? acc_in : '0;
      if (finish) begin
         if ((|acc_in) && (acc_in == prev_key_ff)) begin
            held_in   = held_sum[HoldW] ? {HoldW{1'b1}} : held_sum[HoldW-1:0];
            repeat_in = 1'b1;
         end else begin
            held_in = '0;
         end
         prev_key_in = acc_in;
         state_in    = kms_pkg::ST_IDLE;
         pend_in     = '0;
         in_pos_in   = '0;
         out_pos_in  = '0;
         acc_in      = '0;
      end

      out_bit_new = pos_bit(out_pos_in);
      if (state_in != kms_pkg::ST_SCAN) begin
         drive_in = '0;
      end else if (out_bit_new == gnd_mask_ff) begin
         drive_in = out_mask_ff;
      end else begin
         drive_in = out_mask_ff & ~out_bit_new;
      end
      done_in = finish;

      if (req_take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kms_pkg::ST_IDLE;
         pend_ff      <= '0;
         in_pos_ff    <= '0;
         out_pos_ff   <= '0;
         acc_ff       <= '0;
         prev_key_ff  <= '0;
         held_ff      <= '0;
         repeat_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            state_ff    <= state_in;
            pend_ff     <= pend_in;
            in_pos_ff   <= in_pos_in;
            out_pos_ff  <= out_pos_in;
            acc_ff      <= acc_in;
            prev_key_ff <= prev_key_in;
            held_ff     <= held_in;
            repeat_ff   <= repeat_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         drive_ff <= drive_in;
         done_ff  <= done_in;
         code_ff  <= code_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_drive_levels = drive_ff;
   assign rsp_scan_done    = done_ff;
   assign rsp_key_code     = code_ff;
   assign rsp_hold_time    = held_ff;
   assign rsp_repeat_flag  = repeat_ff;

endmodule

// ----- design/kms_checker.sv -----
// port-level checks for the key matrix scanner, bound to the top level
`include "key_matrix_scanner_top_macros.svh"

module kms_checker #(
   parameter int PIN_COUNT = kms_pkg::PIN_COUNT_DEFAULT
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [PIN_COUNT-1:0]           rsp_drive_levels,
   input logic                           rsp_scan_done,
   input logic [PIN_COUNT-1:0]           rsp_key_code,
   input logic [kms_pkg::HOLD_WIDTH-1:0] rsp_hold_time,
   input logic                           rsp_repeat_flag
);

   // a finished scan leaves the matrix undriven
   `KMS_ASSERT_NOW(a_done_idle_drive, clock, reset, rsp_valid && rsp_scan_done, rsp_drive_levels == '0)
   // key code only shows on a finishing beat
   `KMS_ASSERT_NOW(a_code_only_done, clock, reset, rsp_valid && !rsp_scan_done, rsp_key_code == '0)
   // hold time only grows after a repeat
   `KMS_ASSERT_NOW(a_hold_needs_flag, clock, reset, rsp_valid && (rsp_hold_time != '0), rsp_repeat_flag)
   // every sample beat yields a result beat on the next cycle
   `KMS_ASSERT_NEXT(a_one_cycle_latency, clock, reset, req_valid && !req_stall, rsp_valid)
   // a stalled result beat holds
   `KMS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_key_code) && $stable(rsp_hold_time))

endmodule

bind key_matrix_scanner_top kms_checker #(.PIN_COUNT(PIN_COUNT)) u_kms_checker (.*);
